// ===== sv/memory_map_line_parser_macros.svh =====
// Assertion macros used by the memory map line parser checker.
`ifndef MEMORY_MAP_LINE_PARSER_MACROS_SVH
`define MEMORY_MAP_LINE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MMLP_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("memory map line parser check failed");

// Next-cycle implication, disabled while reset is high.
`define MMLP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("memory map line parser check failed");

// Property that must hold in the cycle after reset is seen.
`define MMLP_ASSERT_AFTER_RESET(label, clk, rst, prop) \
   label: assert property (@(posedge clk) (rst) |=> (prop)) \
      else $error("memory map line parser reset check failed");

`endif

// ===== sv/mmlp_pkg.sv =====
// Types, constants and helper functions of the memory map line parser.
package mmlp_pkg;

   localparam int MAX_LINE = 4096;
   localparam int POS_W    = $clog2(MAX_LINE + 1);
   localparam int NAME_W   = 12;
   localparam int PHASE_W  = 5;
   localparam int PH_COUNT = 17;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DASH  = "-";
   localparam logic [7:0] CHAR_COLON = ":";
   localparam logic [7:0] CHAR_PRIV  = "p";
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] PERM_YES [4] = '{"r", "w", "x", "s"};

   typedef enum logic [PHASE_W-1:0] {
      PH_SK_BEGIN = 5'd0,
      PH_BEGIN    = 5'd1,
      PH_DASH     = 5'd2,
      PH_SK_END   = 5'd3,
      PH_END      = 5'd4,
      PH_SK_PERMS = 5'd5,
      PH_PERMS    = 5'd6,
      PH_SK_OFF   = 5'd7,
      PH_OFF      = 5'd8,
      PH_SK_MAJ   = 5'd9,
      PH_MAJ      = 5'd10,
      PH_COLON    = 5'd11,
      PH_SK_MIN   = 5'd12,
      PH_MIN      = 5'd13,
      PH_SK_INODE = 5'd14,
      PH_INODE    = 5'd15,
      PH_DONE     = 5'd16
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_NO_DASH   = 3'd2,
      ST_BAD_PERMS = 3'd3,
      ST_NO_COLON  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [63:0]       range_begin;
      logic [63:0]       range_end;
      logic              readable;
      logic              writable;
      logic              executable;
      logic              shared_map;
      logic [63:0]       file_offset;
      logic [63:0]       device_major;
      logic [63:0]       device_minor;
      logic [63:0]       inode_number;
      logic [NAME_W-1:0] name_start;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic [POS_W-1:0]  byte_position;
      logic [63:0]       begin_acc;
      logic [63:0]       end_acc;
      logic [63:0]       offset_acc;
      logic [63:0]       major_acc;
      logic [63:0]       minor_acc;
      logic [63:0]       inode_acc;
      logic [2:0]        perm_char_count;
      logic [3:0]        perm_bits;
      status_type        error_code;
      logic [NAME_W-1:0] name_position;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_SK_BEGIN,
      byte_position:   '0,
      begin_acc:       '0,
      end_acc:         '0,
      offset_acc:      '0,
      major_acc:       '0,
      minor_acc:       '0,
      inode_acc:       '0,
      perm_char_count: '0,
      perm_bits:       '0,
      error_code:      ST_OK,
      name_position:   '0
   };

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= "0" && c <= "9") begin
         d = {1'b0, c[3:0]};
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         d = {1'b0, c[3:0] + 4'd9};
      end else begin
         d = 5'h10;
      end
      return d;
   endfunction

endpackage

// ===== sv/memory_map_line_parser.sv =====
// Memory map line parser: one text byte per item, one result per line.
// Throughput is one byte per cycle while no stalled result holds the output,
// limited by the single per-byte parse step. rsp_valid rises when the result
// for the last byte of a line, parsed from the input register, is registered.
// A line-ending byte waits in the input register only while a stalled result
// holds the output. Synchronous reset clears the parse state and both valid flags.
module memory_map_line_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mmlp_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mmlp_pkg::rsp_type rsp_item
);
   import mmlp_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_item_ff;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_item_ff;
   state_type step_next;
   rsp_type   step_result;
   logic      out_free;
   logic      process;
   logic      accept;
   logic      line_done;

   mmlp_step u_step (
      .st     (state_ff),
      .item   (in_item_ff),
      .nx     (step_next),
      .result (step_result)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign process      = in_valid_ff && (!in_item_ff.end_of_line || out_free);
   assign line_done    = process && in_item_ff.end_of_line;
   assign req_stall    = in_valid_ff && !process;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !process);
   assign rsp_valid_in = line_done || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      if (line_done) state_in = STATE_RESET;
      else if (process) state_in = step_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_item_ff <= req_item;
      if (line_done) rsp_item_ff <= step_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sv/mmlp_step.sv =====
// Per-byte parse step: next parse state and the line result for one byte.
module mmlp_step (
   input  mmlp_pkg::state_type st,
   input  mmlp_pkg::req_type   item,
   output mmlp_pkg::state_type nx,
   output mmlp_pkg::rsp_type   result
);
   import mmlp_pkg::*;

   logic [7:0]        c;
   logic              ws;
   logic              sep;
   logic [4:0]        hd;
   logic              is_hex;
   logic              is_dec;
   logic              perms_full;
   logic [PH_COUNT-1:0] pass;
   phase_type         target;
   logic              found;
   logic [1:0]        pidx;
   logic              perm_alt;
   status_type        status;

   assign c          = item.line_byte;
   assign ws         = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign sep        = ws || (c == CHAR_NUL);
   assign hd         = hex_digit(c);
   assign is_hex     = !hd[4];
   assign is_dec     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign perms_full = st.perm_char_count[2];
   assign pidx       = st.perm_char_count[1:0];
   assign perm_alt   = (pidx == 2'd3) ? (c == CHAR_PRIV) : (c == CHAR_DASH);

   // A phase passes the byte on to the next phase when it does not consume it.
   always_comb begin
      pass              = '0;
      pass[PH_SK_BEGIN] = !ws;
      pass[PH_BEGIN]    = !is_hex;
      pass[PH_SK_END]   = !ws;
      pass[PH_END]      = !is_hex;
      pass[PH_SK_PERMS] = !ws;
      pass[PH_PERMS]    = sep && perms_full;
      pass[PH_SK_OFF]   = !ws;
      pass[PH_OFF]      = !is_hex;
      pass[PH_SK_MAJ]   = !ws;
      pass[PH_MAJ]      = !is_hex;
      pass[PH_SK_MIN]   = !ws;
      pass[PH_MIN]      = !is_hex;
      pass[PH_SK_INODE] = !ws;
   end

   always_comb begin
      target = PH_DONE;
      found  = 1'b0;
      for (int k = 0; k < PH_COUNT; k++) begin
         if (!found && (k >= int'(st.phase)) && !pass[k]) begin
            target = phase_type'(k);
            found  = 1'b1;
         end
      end
   end

   always_comb begin
      nx = st;
      if (st.byte_position < POS_W'(MAX_LINE)) begin
         nx.byte_position = st.byte_position + POS_W'(1);
         if (st.error_code == ST_OK) begin
            nx.phase = target;
            unique case (target)
               PH_BEGIN: nx.begin_acc = {st.begin_acc[59:0], hd[3:0]};
               PH_END:   nx.end_acc = {st.end_acc[59:0], hd[3:0]};
               PH_OFF:   nx.offset_acc = {st.offset_acc[59:0], hd[3:0]};
               PH_MAJ:   nx.major_acc = {st.major_acc[59:0], hd[3:0]};
               PH_MIN:   nx.minor_acc = {st.minor_acc[59:0], hd[3:0]};
               PH_DASH: begin
                  if (!ws) begin
                     if (c == CHAR_DASH) nx.phase = PH_SK_END;
                     else nx.error_code = ST_NO_DASH;
                  end
               end
               PH_COLON: begin
                  if (!ws) begin
                     if (c == CHAR_COLON) nx.phase = PH_SK_MIN;
                     else nx.error_code = ST_NO_COLON;
                  end
               end
               PH_PERMS: begin
                  if (sep) begin
                     nx.error_code = ST_BAD_PERMS;
                  end else if (!perms_full) begin
                     if (c == PERM_YES[pidx]) begin
                        nx.perm_bits[pidx]  = 1'b1;
                        nx.perm_char_count = st.perm_char_count + 3'd1;
                     end else if (perm_alt) begin
                        nx.perm_char_count = st.perm_char_count + 3'd1;
                     end else begin
                        nx.error_code = ST_BAD_PERMS;
                     end
                  end
               end
               PH_INODE: begin
                  if (is_dec) begin
                     nx.inode_acc = {st.inode_acc[60:0], 3'b000}
                                  + {st.inode_acc[62:0], 1'b0}
                                  + 64'(c[3:0]);
                  end else begin
                     nx.name_position = NAME_W'(st.byte_position);
                     nx.phase         = PH_DONE;
                  end
               end
               PH_SK_BEGIN, PH_SK_END, PH_SK_PERMS, PH_SK_OFF, PH_SK_MAJ,
               PH_SK_MIN, PH_SK_INODE, PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      if (nx.byte_position >= POS_W'(MAX_LINE)) begin
         status = ST_TOO_LONG;
      end else if (nx.error_code != ST_OK) begin
         status = nx.error_code;
      end else if (nx.phase <= PH_DASH) begin
         status = ST_NO_DASH;
      end else if (nx.phase < PH_PERMS
                   || (nx.phase == PH_PERMS && !nx.perm_char_count[2])) begin
         status = ST_BAD_PERMS;
      end else if (nx.phase <= PH_COLON) begin
         status = ST_NO_COLON;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result        = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.range_begin  = nx.begin_acc;
         result.range_end    = nx.end_acc;
         result.readable     = nx.perm_bits[0];
         result.writable     = nx.perm_bits[1];
         result.executable   = nx.perm_bits[2];
         result.shared_map   = nx.perm_bits[3];
         result.file_offset  = nx.offset_acc;
         result.device_major = nx.major_acc;
         result.device_minor = nx.minor_acc;
         result.inode_number = nx.inode_acc;
         result.name_start   = (nx.phase == PH_DONE) ? nx.name_position
                                                     : NAME_W'(nx.byte_position);
      end
   end

endmodule

// ===== sv/mmlp_checker.sv =====
// Port-level checker for the memory map line parser, bound to the top level.
`include "memory_map_line_parser_macros.svh"

module mmlp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mmlp_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mmlp_pkg::rsp_type rsp_item
);
   import mmlp_pkg::*;

   logic payload_zero;
   logic is_error;
   logic req_seen;

   assign payload_zero = ({rsp_item.range_begin, rsp_item.range_end, rsp_item.readable,
                           rsp_item.writable, rsp_item.executable, rsp_item.shared_map,
                           rsp_item.file_offset, rsp_item.device_major,
                           rsp_item.device_minor, rsp_item.inode_number,
                           rsp_item.name_start} == '0);
   assign is_error     = (rsp_item.status != ST_OK);
   assign req_seen     = req_valid && (req_item.line_byte == req_item.line_byte);

   `MMLP_ASSERT_AFTER_RESET(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `MMLP_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `MMLP_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && is_error, payload_zero)
   `MMLP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `MMLP_ASSERT_NOW(a_stall_only_full, clock, reset, req_seen && req_stall, rsp_valid)

endmodule

bind memory_map_line_parser mmlp_checker u_mmlp_checker (.*);
